@@ rtl/silp_pkg.sv @@
// Shared types and constants for the signed integer literal parser.
// No dependencies; every other rtl file imports this package.
package silp_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned QDEPTH   = 2;

  // ASCII code points the classifier looks for
  localparam logic [CP_W-1:0] CH_0     = CP_W'(8'h30);
  localparam logic [CP_W-1:0] CH_1     = CP_W'(8'h31);
  localparam logic [CP_W-1:0] CH_9     = CP_W'(8'h39);
  localparam logic [CP_W-1:0] CH_LA    = CP_W'(8'h61);
  localparam logic [CP_W-1:0] CH_LF    = CP_W'(8'h66);
  localparam logic [CP_W-1:0] CH_UA    = CP_W'(8'h41);
  localparam logic [CP_W-1:0] CH_UF    = CP_W'(8'h46);
  localparam logic [CP_W-1:0] CH_LX    = CP_W'(8'h78);
  localparam logic [CP_W-1:0] CH_UX    = CP_W'(8'h58);
  localparam logic [CP_W-1:0] CH_MINUS = CP_W'(8'h2d);
  localparam logic [CP_W-1:0] CH_PLUS  = CP_W'(8'h2b);

  // Offset from the low nibble of a-f / A-F to the digit value
  localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = DIGIT_W'(9);

  typedef enum logic [2:0] {
    CLS_EOT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_ZERO,
    CLS_DEC,     // 1..9
    CLS_X,       // x or X
    CLS_HEXAF,   // a-f or A-F
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [DIGIT_W-1:0] digit;
  } qentry_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEXPRE = 3'd3,
    PH_HEX    = 3'd4,
    PH_DEC    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONUM   = 2'd1,
    ST_SIGNONLY = 2'd2,
    ST_HEXEMPTY = 2'd3
  } status_t;

endpackage

@@ rtl/silp_if.sv @@
// Valid/ready channel interfaces for the parser's input and result beats.
// Depends on silp_pkg for field widths.
interface silp_in_if import silp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;

  modport source (output valid, code_point, end_of_text, input ready);
  modport sink   (input valid, code_point, end_of_text, output ready);
endinterface

interface silp_out_if import silp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [1:0]                status;
  logic                      left_over;

  modport source (output valid, value, status, left_over, input ready);
  modport sink   (input valid, value, status, left_over, output ready);
endinterface

@@ rtl/signed_integer_literal_parser_top.sv @@
// Top level of the signed integer literal parser.
// Depends on silp_pkg, silp_if, silp_front, silp_queue and silp_back.
//
// Usage:
//   items   : sink channel, one code point (or end-of-text marker) per beat.
//   results : source channel, one beat per finished literal carrying value,
//             status and left_over. Beats that do not end a literal give none.
//   Path: the edge that accepts a beat writes it into the queue; the back
//   end pops it once it is at the head and the result register can take it,
//   and the result register loads at the edge of that pop and drives results.
//   Throughput: one beat per cycle, sustained while results does not stall;
//   the phase machine updates the accumulator with one shift-and-add per beat.
//   Stall: while a result waits on a stalled results channel the result
//   register holds and the back end stops popping the queue. The queue then
//   fills and items.ready drops once it holds QUEUE_DEPTH beats.
//   Reset: synchronous, active high; empties the queue, drops results.valid
//   and returns the parser to idle with a cleared accumulator.
module signed_integer_literal_parser_top import silp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  silp_in_if.sink     items,
  silp_out_if.source  results
);

  logic    push;
  logic    queue_full;
  logic    pop;
  logic    avail;
  qentry_t push_entry;
  qentry_t head;

  // classify the incoming code point
  silp_front u_front (
    .items      (items),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // decouples intake from the phase machine
  silp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .avail      (avail),
    .head       (head)
  );

  // phase machine, accumulator and result register
  silp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ rtl/silp_front.sv @@
// Front end: takes input beats and classifies each code point.
// Depends on silp_pkg and silp_if; feeds silp_queue.
module silp_front import silp_pkg::*; (
  silp_in_if.sink  items,
  input  logic     queue_full,
  output logic     push,
  output qentry_t  entry
);

  logic [CP_W-1:0] cp;

  assign cp          = items.code_point;
  assign items.ready = !queue_full;
  assign push        = items.valid && !queue_full;

  always_comb begin
    entry.digit = cp[DIGIT_W-1:0];
    priority if (items.end_of_text) begin
      entry.cls = CLS_EOT;
    end else if (cp == CH_MINUS) begin
      entry.cls = CLS_MINUS;
    end else if (cp == CH_PLUS) begin
      entry.cls = CLS_PLUS;
    end else if (cp == CH_0) begin
      entry.cls = CLS_ZERO;
    end else if (cp >= CH_1 && cp <= CH_9) begin
      entry.cls = CLS_DEC;
    end else if (cp == CH_LX || cp == CH_UX) begin
      entry.cls = CLS_X;
    end else if ((cp >= CH_LA && cp <= CH_LF) || (cp >= CH_UA && cp <= CH_UF)) begin
      entry.cls   = CLS_HEXAF;
      entry.digit = cp[DIGIT_W-1:0] + HEX_LETTER_OFS;
    end else begin
      entry.cls = CLS_OTHER;
    end
  end

endmodule

@@ rtl/silp_queue.sv @@
// Short queue of classified beats between front and back ends.
// Depends on silp_pkg.
module silp_queue import silp_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    full,
  input  logic    pop,
  output logic    avail,
  output qentry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  qentry_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/silp_back.sv @@
// Back end: literal phase machine, accumulator and result register.
// Depends on silp_pkg and silp_if; drains silp_queue.
module silp_back import silp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  qentry_t   head,
  output logic      pop,
  silp_out_if.source results
);

  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               fin;
  status_t            fin_status;
  logic               fin_left;
  logic [VALUE_W-1:0] digit_ext;
  logic [VALUE_W-1:0] acc_x10;
  logic [VALUE_W-1:0] acc_x16;
  logic [VALUE_W-1:0] fin_value;
  logic               is_dec;
  logic               is_hex;
  logic               out_valid;

  assign pop       = avail && (!out_valid || results.ready);
  assign digit_ext = VALUE_W'(head.digit);
  assign acc_x10   = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0} + digit_ext;
  assign acc_x16   = {acc[VALUE_W-5:0], head.digit};
  assign is_dec    = (head.cls == CLS_ZERO) || (head.cls == CLS_DEC);
  assign is_hex    = is_dec || (head.cls == CLS_HEXAF);

  // next phase
  always_comb begin
    phase_next = phase;
    if (pop) begin
      unique case (phase)
        PH_ZERO: begin
          if (head.cls == CLS_X) phase_next = PH_HEXPRE;
          else if (is_dec)       phase_next = PH_DEC;
          else                   phase_next = PH_IDLE;
        end
        PH_HEXPRE: begin
          phase_next = is_hex ? PH_HEX : PH_IDLE;
        end
        PH_HEX: begin
          phase_next = is_hex ? PH_HEX : PH_IDLE;
        end
        PH_DEC: begin
          phase_next = is_dec ? PH_DEC : PH_IDLE;
        end
        default: begin  // idle or after sign
          if (phase == PH_IDLE && (head.cls == CLS_MINUS || head.cls == CLS_PLUS)) begin
            phase_next = PH_SIGNED;
          end else if (head.cls == CLS_ZERO) begin
            phase_next = PH_ZERO;
          end else if (head.cls == CLS_DEC) begin
            phase_next = PH_DEC;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  // datapath and result decision
  always_comb begin
    acc_next      = acc;
    negative_next = negative;
    fin           = 1'b0;
    fin_status    = ST_OK;
    fin_left      = head.cls != CLS_EOT;
    unique case (phase)
      PH_ZERO: begin
        if (head.cls == CLS_X) begin
          acc_next = acc;
        end else if (is_dec) begin
          acc_next = digit_ext;
        end else begin
          fin = 1'b1;
        end
      end
      PH_HEXPRE: begin
        if (is_hex) begin
          acc_next = digit_ext;
        end else begin
          fin        = 1'b1;
          fin_status = ST_HEXEMPTY;
        end
      end
      PH_HEX: begin
        if (is_hex) acc_next = acc_x16;
        else        fin      = 1'b1;
      end
      PH_DEC: begin
        if (is_dec) acc_next = acc_x10;
        else        fin      = 1'b1;
      end
      default: begin
        if (phase == PH_IDLE && (head.cls == CLS_MINUS || head.cls == CLS_PLUS)) begin
          negative_next = (head.cls == CLS_MINUS);
        end else if (is_dec) begin
          acc_next = digit_ext;
        end else begin
          fin        = 1'b1;
          fin_status = (phase == PH_IDLE) ? ST_NONUM : ST_SIGNONLY;
        end
      end
    endcase
    if (fin) begin
      acc_next      = '0;
      negative_next = 1'b0;
    end
  end

  always_comb begin
    if (fin_status != ST_OK) fin_value = '0;
    else if (negative)       fin_value = '0 - acc;
    else                     fin_value = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      negative <= 1'b0;
      acc      <= '0;
    end else begin
      phase <= phase_next;
      if (pop) begin
        negative <= negative_next;
        acc      <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && fin) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && fin) begin
      results.value     <= fin_value;
      results.status    <= fin_status;
      results.left_over <= fin_left;
    end
  end

  assign results.valid = out_valid;

`ifndef ASSERT_OFF
  a_no_pop_into_stall: assert property (@(posedge clk) disable iff (rst)
    pop && out_valid |-> results.ready)
    else $error("queue popped while result register stalled");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    pop && fin |=> phase == PH_IDLE && acc == '0 && !negative)
    else $error("state not cleared after result");

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.status != ST_OK |-> results.value == '0)
    else $error("non-zero value with failure status");

  a_eot_always_finishes: assert property (@(posedge clk) disable iff (rst)
    pop && head.cls == CLS_EOT |-> fin && !fin_left)
    else $error("end of text did not close the literal");
`endif

endmodule

@@ tb/signed_integer_literal_parser_top_tb.sv @@
// Testbench for signed_integer_literal_parser_top: drives code point beats and checks every
// result beat against a built-in parser of its own. Depends on silp_pkg, silp_if and the RTL.
`timescale 1ns / 100ps

module signed_integer_literal_parser_top_tb;
  import silp_pkg::*;

  // Extra characters used as terminators and noise
  localparam logic [CP_W-1:0] CH_SPACE = CP_W'(8'h20);
  localparam logic [CP_W-1:0] CH_COMMA = CP_W'(8'h2c);
  localparam logic [CP_W-1:0] CH_LG    = CP_W'(8'h67);
  localparam logic [CP_W-1:0] CP_MAX   = CP_W'(21'h10ffff); // top of Unicode
  localparam logic [CP_W-1:0] CP_ALL   = CP_W'(21'h1fffff); // beyond Unicode
  localparam int unsigned RANDOM_BEATS = 1350;
  localparam int unsigned GAP_PCT      = 25;
  // beat window in which neither side idles
  localparam int unsigned CALM_FROM    = 500;
  localparam int unsigned CALM_TO      = 850;
  localparam int unsigned TAIL_CYCLES  = 10;

  typedef struct {
    logic [CP_W-1:0] cp;
    logic            eot;
  } text_beat_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic                      left_over;
  } literal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  silp_in_if  items_if ();
  silp_out_if results_if ();

  signed_integer_literal_parser_top u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state kept by the testbench
  phase_t               lit_phase = PH_IDLE;
  logic                 lit_negative = 1'b0;
  logic [VALUE_W-1:0]   lit_acc = '0;

  text_beat_t  pending_beats[$];
  literal_t    expected_lits[$];
  int unsigned beats_taken = 0;
  int unsigned total_beats = 0;
  int unsigned err_count = 0;

  // Closes the literal in hand and returns the parser to idle.
  function automatic void close_literal(input status_t st, input logic left,
                                        output literal_t res);
    res.value     = (st == ST_OK) ? (lit_negative ? -lit_acc : lit_acc) : '0;
    res.status    = st;
    res.left_over = left;
    lit_phase     = PH_IDLE;
    lit_negative  = 1'b0;
    lit_acc       = '0;
  endfunction

  // Advances the parser by one beat; returns 1 when the beat closes a literal.
  function automatic bit parse_beat(input logic [CP_W-1:0] cp, input logic eot,
                                    output literal_t res);
    logic               is_dec;
    logic               is_hex;
    logic [VALUE_W-1:0] digit;
    is_dec = 1'b0;
    is_hex = 1'b1;
    digit  = '0;
    if (cp >= CH_0 && cp <= CH_9) begin
      is_dec = 1'b1;
      digit  = VALUE_W'(cp - CH_0);
    end else if (cp >= CH_LA && cp <= CH_LF) begin
      digit = VALUE_W'(cp - CH_LA) + 64'd10;
    end else if (cp >= CH_UA && cp <= CH_UF) begin
      digit = VALUE_W'(cp - CH_UA) + 64'd10;
    end else begin
      is_hex = 1'b0;
    end
    res.value     = '0;
    res.status    = ST_OK;
    res.left_over = 1'b0;

    case (lit_phase)
      PH_ZERO: begin
        if (eot) begin
          close_literal(ST_OK, 1'b0, res);
          return 1;
        end
        if (cp == CH_LX || cp == CH_UX) begin
          lit_phase = PH_HEXPRE;
          return 0;
        end
        // leading zero then more digits is plain decimal
        if (is_dec) begin
          lit_acc   = digit;
          lit_phase = PH_DEC;
          return 0;
        end
        close_literal(ST_OK, 1'b1, res);
        return 1;
      end
      PH_HEXPRE: begin
        if (eot) begin
          close_literal(ST_HEXEMPTY, 1'b0, res);
          return 1;
        end
        if (is_hex) begin
          lit_acc   = digit;
          lit_phase = PH_HEX;
          return 0;
        end
        close_literal(ST_HEXEMPTY, 1'b1, res);
        return 1;
      end
      PH_HEX: begin
        if (eot) begin
          close_literal(ST_OK, 1'b0, res);
          return 1;
        end
        if (is_hex) begin
          lit_acc = lit_acc * 64'd16 + digit;
          return 0;
        end
        close_literal(ST_OK, 1'b1, res);
        return 1;
      end
      PH_DEC: begin
        if (eot) begin
          close_literal(ST_OK, 1'b0, res);
          return 1;
        end
        if (is_dec) begin
          lit_acc = lit_acc * 64'd10 + digit;
          return 0;
        end
        close_literal(ST_OK, 1'b1, res);
        return 1;
      end
      default: begin
        // idle or just after a sign; a second sign is an ordinary non-digit
        if (eot) begin
          close_literal((lit_phase == PH_SIGNED) ? ST_SIGNONLY : ST_NONUM, 1'b0, res);
          return 1;
        end
        if (lit_phase != PH_SIGNED && (cp == CH_MINUS || cp == CH_PLUS)) begin
          lit_negative = (cp == CH_MINUS);
          lit_phase    = PH_SIGNED;
          return 0;
        end
        if (cp == CH_0) begin
          lit_acc   = '0;
          lit_phase = PH_ZERO;
          return 0;
        end
        if (is_dec) begin
          lit_acc   = digit;
          lit_phase = PH_DEC;
          return 0;
        end
        close_literal((lit_phase == PH_SIGNED) ? ST_SIGNONLY : ST_NONUM, 1'b1, res);
        return 1;
      end
    endcase
  endfunction

  // Random idling on either side, switched off across a window of beats
  function automatic bit take_gap();
    if (beats_taken >= CALM_FROM && beats_taken < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < GAP_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending beat once the current one is taken.
  // The beat accepted at this edge is fed to the parser model first.
  // ---------------------------------------------------------------------------
  text_beat_t next_beat;
  literal_t   lit_out;

  always @(posedge clk) begin
    if (rst) begin
      items_if.valid       <= 1'b0;
      items_if.code_point  <= '0;
      items_if.end_of_text <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        if (parse_beat(items_if.code_point, items_if.end_of_text, lit_out))
          expected_lits = {expected_lits, lit_out};
        beats_taken++;
      end
      if (!items_if.valid || items_if.ready) begin
        if (pending_beats.size() != 0 && !take_gap()) begin
          next_beat = pending_beats.pop_front();
          items_if.valid       <= 1'b1;
          items_if.code_point  <= next_beat.cp;
          items_if.end_of_text <= next_beat.eot;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result beat is matched against the oldest
  // expected literal, field by field. Ready is dropped at random.
  // ---------------------------------------------------------------------------
  literal_t want;

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (expected_lits.size() == 0) begin
          $error("result beat with none expected: value %0d status %0d left_over %0b",
                 results_if.value, results_if.status, results_if.left_over);
          err_count++;
        end else begin
          want = expected_lits.pop_front();
          if (results_if.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, results_if.value);
            err_count++;
          end
          if (results_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, results_if.status);
            err_count++;
          end
          if (results_if.left_over !== want.left_over) begin
            $error("left_over: expected %0b, got %0b", want.left_over,
                   results_if.left_over);
            err_count++;
          end
        end
      end
      results_if.ready <= !take_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_beat(input logic [CP_W-1:0] cp, input logic eot);
    text_beat_t b;
    b.cp  = cp;
    b.eot = eot;
    pending_beats = {pending_beats, b};
  endtask

  // Mostly ASCII, with the interesting characters and the odd wide code point
  function automatic logic [CP_W-1:0] rand_cp();
    logic [CP_W-1:0] key[12];
    key = '{CH_0, CH_9, CH_LA, CH_LF, CH_UA, CH_UF, CH_LX, CH_UX,
            CH_MINUS, CH_PLUS, CH_SPACE, CH_LG};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CP_W'($urandom_range(0, 127));
      4, 5, 6:    return key[$urandom_range(0, 11)];
      7, 8:       return CP_W'($urandom_range(0, 32'h10ffff));
      default:    return CP_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CP_W-1:0] rand_hex_digit();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return CH_0 + CP_W'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CP_W'(d - 10);
  endfunction

  // Ends a literal: end of text, or a code point that is not a decimal digit
  task automatic add_terminator();
    logic [CP_W-1:0] cp;
    if ($urandom_range(0, 99) < 40) begin
      add_beat(rand_cp(), 1'b1);
    end else begin
      do cp = rand_cp(); while (cp >= CH_0 && cp <= CH_9);
      add_beat(cp, 1'b0);
    end
  endtask

  task automatic add_literal();
    int unsigned form;
    int unsigned n;
    int unsigned pattern;
    case ($urandom_range(0, 2))
      1: add_beat(CH_PLUS, 1'b0);
      2: add_beat(CH_MINUS, 1'b0);
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) add_beat($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
    form = $urandom_range(0, 9);
    if (form <= 3) begin
      add_beat(CH_0, 1'b0);
      add_beat($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
      // now and then run past 16 digits so the accumulator wraps
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
      pattern = $urandom_range(0, 9);
      for (int unsigned i = 0; i < n; i++) begin
        if (n == 16 && pattern == 0)
          add_beat((i == 0) ? CH_0 + CP_W'(7) : CH_LF, 1'b0);
        else if (n == 16 && pattern == 1)
          add_beat((i == 0) ? CH_0 + CP_W'(8) : CH_0, 1'b0);
        else
          add_beat(rand_hex_digit(), 1'b0);
      end
    end else if (form <= 7) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 26) : $urandom_range(1, 19);
      for (int unsigned i = 0; i < n; i++)
        add_beat(CH_0 + CP_W'($urandom_range(0, 9)), 1'b0);
    end else if (form == 8) begin
      add_beat(CH_0, 1'b0);
    end else if ($urandom_range(0, 1)) begin
      add_beat(CH_0, 1'b0);
      add_beat($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
    end
    add_terminator();
  endtask

  initial begin
    items_if.valid       = 1'b0;
    items_if.code_point  = '0;
    items_if.end_of_text = 1'b0;
    results_if.ready     = 1'b0;

    // No literal: end of text, then a non-digit, in idle
    add_beat(CH_9, 1'b1);
    add_beat('0, 1'b0);
    // Sign then a second sign, and sign then end of text
    add_beat(CH_MINUS, 1'b0);
    add_beat(CH_PLUS, 1'b0);
    add_beat(CH_PLUS, 1'b0);
    add_beat(CH_0, 1'b1);
    // Hex prefix with no hex digit, closed by a character and by end of text
    add_beat(CH_0, 1'b0);
    add_beat(CH_LX, 1'b0);
    add_beat(CH_LG, 1'b0);
    add_beat(CH_0, 1'b0);
    add_beat(CH_UX, 1'b0);
    add_beat(CP_MAX, 1'b1);
    // Lone zero, both ways
    add_beat(CH_0, 1'b0);
    add_beat(CH_SPACE, 1'b0);
    add_beat(CH_0, 1'b0);
    add_beat(CH_0 + CP_W'(7), 1'b1);
    // Leading zero read as decimal, ended by the top code point
    add_beat(CH_0, 1'b0);
    add_beat(CH_0 + CP_W'(7), 1'b0);
    add_beat(CH_9, 1'b0);
    add_beat(CP_MAX, 1'b0);
    // Code point beyond Unicode in idle
    add_beat(CP_ALL, 1'b0);
    // Negative hex with mixed case
    add_beat(CH_MINUS, 1'b0);
    add_beat(CH_0, 1'b0);
    add_beat(CH_UX, 1'b0);
    add_beat(CH_UF, 1'b0);
    add_beat(CH_LA, 1'b0);
    add_beat(CH_UA, 1'b0);
    add_beat(CH_COMMA, 1'b1);

    // Random part: mostly well-formed literals, some noise
    total_beats = pending_beats.size() + RANDOM_BEATS;
    while (pending_beats.size() < total_beats) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4))
          add_beat(rand_cp(), $urandom_range(0, 7) == 0);
      end else begin
        add_literal();
      end
    end
    total_beats = pending_beats.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (beats_taken == total_beats);
    while (expected_lits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("signed_integer_literal_parser_top_tb: clean");
    else
      $display("signed_integer_literal_parser_top_tb: errors");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(2_000_000);
    $display("signed_integer_literal_parser_top_tb: errors");
    $finish;
  end

endmodule
